@@ design/gpb_pkg.sv @@
// ----------------------------------------------------------------------------
// gpb_pkg: shared types and constants for the ground plane back-projection
// Holds the object kind codes, the assumed sizes, register indexes and the
// side-band record that travels next to the dividers.
// ----------------------------------------------------------------------------
package gpb_pkg;

    // object kind codes
    localparam logic [1:0] KIND_PED     = 2'd0;
    localparam logic [1:0] KIND_VEHICLE = 2'd1;
    localparam logic [1:0] KIND_UNKNOWN = 2'd2;

    // register indexes
    localparam logic [2:0] REG_FOCAL_X  = 3'd0;
    localparam logic [2:0] REG_FOCAL_Y  = 3'd1;
    localparam logic [2:0] REG_CENTRE_X = 3'd2;
    localparam logic [2:0] REG_CENTRE_Y = 3'd3;
    localparam logic [2:0] REG_HEIGHT   = 3'd4;

    // quotient bits produced by each divider
    localparam int QUOT_W = 26;
    // accept edge to result strobe, in cycles
    localparam int LATENCY = QUOT_W + 4;

    localparam logic [23:0] DEPTH_MAX = 24'hFF_FFFF;
    localparam logic [24:0] LAT_MAX   = 25'h0FF_FFFF;
    localparam logic [24:0] LAT_MIN   = 25'h100_0000;

    typedef struct packed {
        logic [11:0] height;
        logic [11:0] width;
        logic [11:0] length;
    } t_size;

    // side-band data carried next to the quotients
    typedef struct packed {
        logic        above;
        logic        neg;
        logic        lzero;
        logic        fxz;
        logic [1:0]  kind;
        logic [15:0] score;
        logic [15:0] height;
    } t_side;

    function automatic logic [1:0] class_to_kind(input logic [7:0] cls);
        logic [1:0] k;
        case (cls)
            8'd0:                    k = KIND_PED;
            8'd2, 8'd3, 8'd5, 8'd7:  k = KIND_VEHICLE;
            default:                 k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

    function automatic t_size kind_size(input logic [1:0] kind);
        t_size s;
        case (kind)
            KIND_PED:     s = '{height: 12'd1700, width: 12'd600,  length: 12'd500};
            KIND_VEHICLE: s = '{height: 12'd1500, width: 12'd1800, length: 12'd4000};
            default:      s = '{height: 12'd1000, width: 12'd1000, length: 12'd1000};
        endcase
        return s;
    endfunction

endpackage

@@ design/gpb_div.sv @@
// ----------------------------------------------------------------------------
// gpb_div: pipelined restoring divider
// One quotient bit per stage after an overflow check stage. Accepts a new
// beat every cycle.
// ----------------------------------------------------------------------------
module gpb_div #(
    parameter int NW = 34,
    parameter int DW = 17,
    parameter int QW = 26
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_valid,
    output logic [QW-1:0] o_quot,
    output logic          o_ovf
);
    localparam int WW = (NW > DW + QW) ? NW : DW + QW;

    logic [WW-1:0] r_rem [0:QW];
    logic [DW-1:0] r_den [0:QW];
    logic [QW-1:0] r_q   [0:QW];
    logic [QW:0]   r_ovf;
    logic [QW:0]   r_vld;

    // check whether the quotient fits in QW bits
    always_ff @(posedge i_clk) begin
        r_rem[0] <= WW'(i_num);
        r_den[0] <= i_den;
        r_q[0]   <= '0;
        r_ovf[0] <= (WW'(i_num) >> QW) >= WW'(i_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[QW-1:0], i_valid};
        end
    end

    // resolve one quotient bit per stage, most significant first
    for (genvar g = 1; g <= QW; g++) begin : g_stage
        localparam int B = QW - g;
        logic [WW-1:0] n_sub;
        logic          n_ge;
        assign n_sub = WW'(r_den[g-1]) << B;
        assign n_ge  = r_rem[g-1] >= n_sub;
        always_ff @(posedge i_clk) begin
            r_rem[g] <= n_ge ? (r_rem[g-1] - n_sub) : r_rem[g-1];
            r_q[g]   <= r_q[g-1] | (n_ge ? (QW'(1) << B) : QW'(0));
            r_den[g] <= r_den[g-1];
            r_ovf[g] <= r_ovf[g-1];
        end
    end

    assign o_valid = r_vld[QW];
    assign o_quot  = r_q[QW];
    assign o_ovf   = r_ovf[QW];

endmodule

@@ design/ground_plane_backprojection.sv @@
// ----------------------------------------------------------------------------
// ground_plane_backprojection: detection box to ground plane position
// Pinhole back-projection of the box foot point to depth and lateral offset.
// ----------------------------------------------------------------------------
// Takes one box per cycle (busy is low except in reset) and shows its result
// on a one-cycle o_valid strobe; the receiver cannot stall, so results
// must be taken when shown. A box passes two multiply stages, then two
// pipelined restoring dividers of 27 stages each (an overflow check, then
// one quotient bit per stage) working side by side, and an output stage.
// Registers are read at accept time and must only be written while no box
// is in flight.
module ground_plane_backprojection (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command channel
    input  logic        start,
    output logic        busy,
    input  logic [15:0] i_box_left_x,
    input  logic [15:0] i_box_right_x,
    input  logic [15:0] i_box_bottom_y,
    input  logic [7:0]  i_class_code,
    input  logic [15:0] i_score,
    // result channel
    output logic        o_valid,
    output logic signed [24:0] o_lateral_mm,
    output logic [23:0] o_depth_mm,
    output logic signed [16:0] o_vertical_mm,
    output logic [1:0]  o_object_kind,
    output logic [11:0] o_size_height_mm,
    output logic [11:0] o_size_width_mm,
    output logic [11:0] o_size_length_mm,
    output logic [15:0] o_score_out,
    output logic        o_above_horizon,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gpb_pkg::*;

    logic [15:0] r_focal_x, r_focal_y, r_centre_x, r_centre_y, r_height;
    logic [2:0]  n_idx;
    logic        n_wr, n_acc;

    // configuration registers
    assign n_idx  = paddr[4:2];
    assign n_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x  <= 16'd16000;
            r_focal_y  <= 16'd16000;
            r_centre_x <= 16'd15360;
            r_centre_y <= 16'd8640;
            r_height   <= 16'd1500;
        end else if (n_wr) begin
            case (n_idx)
                REG_FOCAL_X:  r_focal_x  <= pwdata[15:0];
                REG_FOCAL_Y:  r_focal_y  <= pwdata[15:0];
                REG_CENTRE_X: r_centre_x <= pwdata[15:0];
                REG_CENTRE_Y: r_centre_y <= pwdata[15:0];
                REG_HEIGHT:   r_height   <= pwdata[15:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        case (n_idx)
            REG_FOCAL_X:  prdata = {16'd0, r_focal_x};
            REG_FOCAL_Y:  prdata = {16'd0, r_focal_y};
            REG_CENTRE_X: prdata = {16'd0, r_centre_x};
            REG_CENTRE_Y: prdata = {16'd0, r_centre_y};
            REG_HEIGHT:   prdata = {16'd0, r_height};
            default:      prdata = '0;
        endcase
    end

    assign busy  = !i_rst_n;
    assign n_acc = start && !busy;

    // stage 1: foot point differences, height*fy and dv*fx
    logic [16:0] n_su, n_sc;
    logic        n_neg;
    logic [15:0] n_dv;
    logic        r1_vld;
    logic [16:0] r1_du;
    logic [15:0] r1_dv;
    logic [31:0] r1_dnum, r1_dvfx;
    t_side       r1_side;

    assign n_su  = {1'b0, i_box_left_x} + {1'b0, i_box_right_x};
    assign n_sc  = {r_centre_x, 1'b0};
    assign n_neg = n_su < n_sc;
    assign n_dv  = i_box_bottom_y - r_centre_y;

    always_ff @(posedge i_clk) begin
        r1_du          <= n_neg ? (n_sc - n_su) : (n_su - n_sc);
        r1_dv          <= n_dv;
        r1_dnum        <= 32'(r_height) * 32'(r_focal_y);
        r1_dvfx        <= 32'(n_dv) * 32'(r_focal_x);
        r1_side.above  <= i_box_bottom_y <= r_centre_y;
        r1_side.neg    <= n_neg;
        r1_side.lzero  <= 1'b0;
        r1_side.fxz    <= r_focal_x == 16'd0;
        r1_side.kind   <= class_to_kind(i_class_code);
        r1_side.score  <= i_score;
        r1_side.height <= r_height;
    end

    // stage 2: lateral numerator
    logic        r2_vld;
    logic [48:0] r2_lnum;
    logic [31:0] r2_dnum, r2_dvfx;
    logic [15:0] r2_dv;
    t_side       r2_side;
    t_side       n2_side;

    always_ff @(posedge i_clk) begin
        r2_lnum <= 49'(r1_du) * 49'(r1_dnum);
        r2_dnum <= r1_dnum;
        r2_dvfx <= r1_dvfx;
        r2_dv   <= r1_dv;
        r2_side <= r1_side;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else begin
            r1_vld <= n_acc;
            r2_vld <= r1_vld;
        end
    end

    always_comb begin
        n2_side       = r2_side;
        n2_side.lzero = r2_lnum == 49'd0;
    end

    // dividers: rounded quotients as (2n + d) / 2d
    logic [33:0]     n_dnum_r;
    logic [16:0]     n_dden;
    logic [50:0]     n_lnum_r;
    logic [33:0]     n_lden;
    logic            w_dvld, w_lvld;
    logic [QUOT_W-1:0] w_dq, w_lq;
    logic            w_dovf, w_lovf;

    assign n_dnum_r = {1'b0, r2_dnum, 1'b0} + 34'(r2_dv);
    assign n_dden   = {r2_dv, 1'b0};
    assign n_lnum_r = {1'b0, r2_lnum, 1'b0} + 51'({r2_dvfx, 1'b0});
    assign n_lden   = {r2_dvfx, 2'b00};

    gpb_div #(.NW(34), .DW(17), .QW(QUOT_W)) u_depth_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_vld),
        .i_num   (n_dnum_r),
        .i_den   (n_dden),
        .o_valid (w_dvld),
        .o_quot  (w_dq),
        .o_ovf   (w_dovf)
    );

    gpb_div #(.NW(51), .DW(34), .QW(QUOT_W)) u_lat_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r2_vld),
        .i_num   (n_lnum_r),
        .i_den   (n_lden),
        .o_valid (w_lvld),
        .o_quot  (w_lq),
        .o_ovf   (w_lovf)
    );

    // carry the side-band data along the divider stages
    t_side r_side [0:QUOT_W];
    always_ff @(posedge i_clk) begin
        r_side[0] <= n2_side;
        for (int i = 1; i <= QUOT_W; i++) begin
            r_side[i] <= r_side[i-1];
        end
    end

    // output stage: saturate and select
    t_side       n_s;
    logic [23:0] n_depth;
    logic [24:0] n_lat;
    logic        n_lsat;
    t_size       n_size;

    assign n_s    = r_side[QUOT_W];
    assign n_lsat = n_s.fxz || w_lovf || (w_lq[QUOT_W-1:24] != '0);
    assign n_size = kind_size(n_s.kind);

    always_comb begin
        if (n_s.above) begin
            n_depth = '0;
        end else if (w_dovf || (w_dq[QUOT_W-1:24] != '0)) begin
            n_depth = DEPTH_MAX;
        end else begin
            n_depth = w_dq[23:0];
        end
        if (n_s.above || n_s.lzero) begin
            n_lat = '0;
        end else if (n_s.neg) begin
            n_lat = n_lsat ? LAT_MIN : (25'd0 - {1'b0, w_lq[23:0]});
        end else begin
            n_lat = n_lsat ? LAT_MAX : {1'b0, w_lq[23:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_dvld && w_lvld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_lateral_mm     <= n_lat;
        o_depth_mm       <= n_depth;
        o_vertical_mm    <= 17'd0 - {1'b0, n_s.height};
        o_object_kind    <= n_s.kind;
        o_size_height_mm <= n_size.height;
        o_size_width_mm  <= n_size.width;
        o_size_length_mm <= n_size.length;
        o_score_out      <= n_s.score;
        o_above_horizon  <= n_s.above;
    end

endmodule

@@ design/gpb_checker.sv @@
// ----------------------------------------------------------------------------
// gpb_port_checks: port-level checks for the ground plane back-projection
// Watches result timing and result field consistency on the top level.
// ----------------------------------------------------------------------------
module gpb_port_checks (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [24:0] o_lateral_mm,
    input logic [23:0] o_depth_mm,
    input logic [1:0]  o_object_kind,
    input logic [11:0] o_size_height_mm,
    input logic [11:0] o_size_length_mm,
    input logic        o_above_horizon,
    input logic        pready
);
    import gpb_pkg::*;

    // every result beat follows an accepted command by the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LATENCY))
        else $error("result beat without matching command");

    // a foot above the horizon gives zero depth and lateral
    a_horizon: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_above_horizon) |-> (o_depth_mm == '0 && o_lateral_mm == '0))
        else $error("above horizon with nonzero position");

    // vehicle height and length match the kind
    a_vehicle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_object_kind == KIND_VEHICLE) |->
            (o_size_height_mm == 12'd1500 && o_size_length_mm == 12'd4000))
        else $error("vehicle size mismatch");

    // outside reset the block never holds commands off
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy && pready)
        else $error("busy or not ready outside reset");

endmodule

bind ground_plane_backprojection gpb_port_checks u_gpb_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .o_valid          (o_valid),
    .o_lateral_mm     (o_lateral_mm),
    .o_depth_mm       (o_depth_mm),
    .o_object_kind    (o_object_kind),
    .o_size_height_mm (o_size_height_mm),
    .o_size_length_mm (o_size_length_mm),
    .o_above_horizon  (o_above_horizon),
    .pready           (pready)
);
